>>> hw/rtl/keyed_table_engine_top_assert.svh
// Assertion macros used by the checker file of the keyed table engine.
`ifndef KEYED_TABLE_ENGINE_TOP_ASSERT_SVH
`define KEYED_TABLE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define KTE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define KTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/kte_pkg.sv
package kte_pkg;

   localparam int ENTRIES     = 32;
   localparam int KEY_BITS    = 16;
   localparam int VALUE_BITS  = 32;
   localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS    = $clog2(ENTRIES + 1);
   localparam int ACTION_BITS = 3;
   localparam int STATUS_BITS = 2;

   localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_INSERT = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_ERASE  = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_LOOKUP = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_COUNT  = 3'd4;

   localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_DUP     = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_MISSING = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } kte_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_busy;
   } kte_stat_type;

endpackage

>>> hw/rtl/kte_req_if.sv
interface kte_req_if;
   import kte_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [ACTION_BITS-1:0]        action;
   logic [KEY_BITS-1:0]           key;
   logic signed [VALUE_BITS-1:0]  value;

   modport source (output valid, output action, output key, output value, input ready);
   modport sink   (input valid, input action, input key, input value, output ready);
endinterface

>>> hw/rtl/kte_rsp_if.sv
interface kte_rsp_if;
   import kte_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [STATUS_BITS-1:0]        status;
   logic                          found;
   logic signed [VALUE_BITS-1:0]  value_out;
   logic [CNT_BITS-1:0]           match_count;
   logic [CNT_BITS-1:0]           occupancy;

   modport source (output valid, output status, output found, output value_out,
                   output match_count, output occupancy, input ready);
   modport sink   (input valid, input status, input found, input value_out,
                   input match_count, input occupancy, output ready);
endinterface

>>> hw/rtl/kte_ctrl.sv
module kte_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kte_pkg::kte_stat_type stat,
   output kte_pkg::kte_cmd_type  cmd
);
   import kte_pkg::*;

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   // No request is taken while reset is high.
   assign req_ready = (state_ff == STATE_IDLE) && !reset;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         STATE_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            // The result register must be free before the table is updated.
            if (!stat.rsp_busy) begin
               cmd.execute = 1'b1;
               state_in    = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/kte_datapath.sv
module kte_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kte_pkg::kte_cmd_type                 cmd,
   output kte_pkg::kte_stat_type                stat,
   input  logic [kte_pkg::ACTION_BITS-1:0]      req_action,
   input  logic [kte_pkg::KEY_BITS-1:0]         req_key,
   input  logic signed [kte_pkg::VALUE_BITS-1:0] req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [kte_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic                                 rsp_found,
   output logic signed [kte_pkg::VALUE_BITS-1:0] rsp_value_out,
   output logic [kte_pkg::CNT_BITS-1:0]         rsp_match_count,
   output logic [kte_pkg::CNT_BITS-1:0]         rsp_occupancy
);
   import kte_pkg::*;

   localparam int PAD = 1 << IDX_BITS;

   // Table storage; only entries below the count are ever meaningful.
   logic [KEY_BITS-1:0]    key_store_ff   [ENTRIES];
   logic [VALUE_BITS-1:0]  value_store_ff [ENTRIES];
   logic [CNT_BITS-1:0]    count_ff;
   logic [CNT_BITS-1:0]    count_in;

   // Captured request and compare results.
   logic [ACTION_BITS-1:0] act_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [VALUE_BITS-1:0]  val_ff;
   logic [ENTRIES-1:0]     key_hit_ff;
   logic [ENTRIES-1:0]     val_hit_ff;
   logic [ENTRIES-1:0]     key_hit_in;
   logic [ENTRIES-1:0]     val_hit_in;

   // Result register.
   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] status_ff;
   logic                   found_ff;
   logic [VALUE_BITS-1:0]  vout_ff;
   logic [CNT_BITS-1:0]    match_ff;
   logic [STATUS_BITS-1:0] status_in;
   logic                   found_in;
   logic [VALUE_BITS-1:0]  vout_in;
   logic [CNT_BITS-1:0]    match_in;

   logic                   hit_any;
   logic                   table_full;
   logic [VALUE_BITS-1:0]  lookup_val;
   logic [ENTRIES-1:0]     shift_mask;
   logic [CNT_BITS-1:0]    pop_count;
   logic                   do_insert;
   logic                   do_erase;

   // Parallel compare against every held entry, done in the accept cycle.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_hit_in[i] = (CNT_BITS'(i) < count_ff) && (key_store_ff[i] == req_key);
         val_hit_in[i] = (CNT_BITS'(i) < count_ff) && (value_store_ff[i] == req_value);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff     <= req_action;
         key_ff     <= req_key;
         val_ff     <= req_value;
         key_hit_ff <= key_hit_in;
         val_hit_ff <= val_hit_in;
      end
   end

   assign hit_any    = |key_hit_ff;
   assign table_full = (count_ff == CNT_BITS'(ENTRIES));

   // Keys are unique, so the hit vector is one-hot and an AND-OR selects the value.
   always_comb begin
      lookup_val = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         lookup_val = lookup_val | (key_hit_ff[i] ? value_store_ff[i] : '0);
      end
   end

   // Entries at and above the erased slot take their upper neighbor.
   for (genvar g = 0; g < ENTRIES; g++) begin : g_mask
      assign shift_mask[g] = |key_hit_ff[g:0];
   end

   // Adder tree for the number of value matches.
   always_comb begin
      logic [CNT_BITS-1:0] tree [IDX_BITS+1][PAD];
      logic [PAD-1:0]      hit_pad;
      hit_pad = PAD'(val_hit_ff);
      for (int j = 0; j < PAD; j++) begin
         tree[0][j] = CNT_BITS'(hit_pad[j]);
      end
      for (int l = 1; l <= IDX_BITS; l++) begin
         for (int j = 0; j < PAD / 2; j++) begin
            tree[l][j]           = tree[l-1][2*j] + tree[l-1][2*j+1];
            tree[l][j + PAD / 2] = '0;
         end
      end
      pop_count = tree[IDX_BITS][0];
   end

   always_comb begin
      status_in = ST_OK;
      found_in  = 1'b0;
      vout_in   = '0;
      match_in  = '0;
      count_in  = count_ff;
      do_insert = 1'b0;
      do_erase  = 1'b0;
      case (act_ff)
         ACT_CLEAR: begin
            count_in = '0;
         end
         ACT_INSERT: begin
            if (hit_any) begin
               status_in = ST_DUP;
               found_in  = 1'b1;
            end else if (table_full) begin
               status_in = ST_FULL;
            end else begin
               do_insert = 1'b1;
               count_in  = count_ff + CNT_BITS'(1);
            end
         end
         ACT_ERASE: begin
            if (hit_any) begin
               found_in = 1'b1;
               do_erase = 1'b1;
               count_in = count_ff - CNT_BITS'(1);
            end else begin
               status_in = ST_MISSING;
            end
         end
         ACT_LOOKUP: begin
            if (hit_any) begin
               found_in = 1'b1;
               vout_in  = lookup_val;
            end else begin
               status_in = ST_MISSING;
            end
         end
         ACT_COUNT: begin
            match_in = pop_count;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_entry
      if (g < ENTRIES - 1) begin : g_shift
         always_ff @(posedge clock) begin
            if (cmd.execute && do_insert && (IDX_BITS'(g) == count_ff[IDX_BITS-1:0])) begin
               key_store_ff[g]   <= key_ff;
               value_store_ff[g] <= val_ff;
            end else if (cmd.execute && do_erase && shift_mask[g]) begin
               key_store_ff[g]   <= key_store_ff[g+1];
               value_store_ff[g] <= value_store_ff[g+1];
            end
         end
      end else begin : g_last
         always_ff @(posedge clock) begin
            if (cmd.execute && do_insert && (IDX_BITS'(g) == count_ff[IDX_BITS-1:0])) begin
               key_store_ff[g]   <= key_ff;
               value_store_ff[g] <= val_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.execute) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         vout_ff   <= vout_in;
         match_ff  <= match_in;
      end
   end

   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_value_out   = vout_ff;
   assign rsp_match_count = match_ff;
   assign rsp_occupancy   = count_ff;

endmodule

>>> hw/rtl/keyed_table_engine_top.sv
// Channel  Direction  Contents
// req_ch   in         action, key, value
// rsp_ch   out        status, found, value_out, match_count, occupancy
//
// In the accept cycle the key and value are compared against every held entry and the hit
// vectors are registered; once the result register is free, the insert, erase shift or
// lookup is applied from the registered hit vectors and the result register is loaded.
// Reset is synchronous; it clears the entry count, the controller state and the result
// valid, and holds req_ch ready low. The key and value stores are not cleared. A waiting
// result does not block the next accept; only that request's update waits for rsp_ch.
module keyed_table_engine_top (
   input  logic       clock,
   input  logic       reset,
   kte_req_if.sink    req_ch,
   kte_rsp_if.source  rsp_ch
);
   import kte_pkg::*;

   kte_cmd_type  cmd;
   kte_stat_type stat;

   // The controller sequences the accept and update cycles.
   kte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the table, the compare logic and the result register.
   kte_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_ch.action),
      .req_key         (req_ch.key),
      .req_value       (req_ch.value),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_found       (rsp_ch.found),
      .rsp_value_out   (rsp_ch.value_out),
      .rsp_match_count (rsp_ch.match_count),
      .rsp_occupancy   (rsp_ch.occupancy)
   );

endmodule

>>> hw/rtl/kte_checker.sv
`include "keyed_table_engine_top_assert.svh"

module kte_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [kte_pkg::STATUS_BITS-1:0]  rsp_status,
   input logic                             rsp_found,
   input logic [kte_pkg::CNT_BITS-1:0]     rsp_occupancy
);
   import kte_pkg::*;

   // Only one request is in work at a time.
   `KTE_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready)
   // A waiting result stays until it is taken.
   `KTE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // The table never reports more entries than it can hold.
   `KTE_ASSERT_IMPLY(a_occ_limit, clock, reset, rsp_valid, rsp_occupancy <= CNT_BITS'(ENTRIES))
   // A present key is never reported as missing or as a full table.
   `KTE_ASSERT_IMPLY(a_found_status, clock, reset, rsp_valid && rsp_found,
      rsp_status == ST_OK || rsp_status == ST_DUP)

endmodule

bind keyed_table_engine_top kte_checker u_kte_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_found     (rsp_ch.found),
   .rsp_occupancy (rsp_ch.occupancy)
);
